@@ hdl/cpgd_pkg.sv @@
`timescale 1ns / 1ps
package cpgd_pkg;
  localparam int unsigned MaxVerticesDefault = 16;
  localparam int unsigned CoordW = 16;
  localparam int unsigned DistW = 32;

  typedef enum logic [1:0] {
    CmdClear  = 2'd0,
    CmdInsert = 2'd1,
    CmdQuery  = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
  } req_t;

  typedef struct packed {
    logic signed [31:0] distance;
    logic               error;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;    // capture request and form the query difference
    logic clr_cnt;     // empty the polygon
    logic rd_en;       // read vertex at rd_addr
    logic wr_en;       // write vertex
    logic wr_new;      // write data is the new vertex, else the shifted one
    logic cnt_inc;
    logic lat_rd;      // latch the read vertex into the compare register
    logic lat_a;       // latch the read vertex as A
    logic lat_b;       // latch the read vertex as B
    logic mul_start;   // form the four partial products
    logic mul2;        // form numerator and divisor from the products
    logic div_start;
    logic div_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic below;       // compare result on the latched vertex
    logic full;
    logic empty;
    logic q_zero;
    logic den_zero;
    logic div_done;
  } sts_t;

  // True when point a lies angularly below point b.
  function automatic logic ang_below(input logic signed [16:0] ax, input logic signed [16:0] ay,
                                     input logic signed [16:0] bx,
                                     input logic signed [16:0] by);
    logic signed [33:0] l;
    logic signed [33:0] r;
    logic res;
    l = ay * bx;
    r = by * ax;
    if (ax == bx && ay == by) res = 1'b0;
    else if (!ax[16] && bx[16]) res = 1'b1;
    else if (ax[16] && !bx[16]) res = 1'b0;
    else res = (l < r);
    return res;
  endfunction
endpackage

@@ hdl/cpgd_if.sv @@
`timescale 1ns / 1ps
interface cpgd_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/cpgd_ram.sv @@
`timescale 1ns / 1ps
module cpgd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem[raddr_i];
  end
endmodule

@@ hdl/cpgd_datapath.sv @@
`timescale 1ns / 1ps
module cpgd_datapath import cpgd_pkg::*; #(
  parameter int unsigned MaxVertices = MaxVerticesDefault,
  localparam int unsigned AW = $clog2(MaxVertices),
  localparam int unsigned CW = $clog2(MaxVertices + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  req_t          req_i,
  input  cmd_t          cmd_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic [AW-1:0] wr_addr_i,
  output sts_t          sts_o,
  output logic [CW-1:0] count_o,
  output logic [1:0]    cmd_code_o,
  output rsp_t          rsp_o
);
  req_t req_q;
  logic [CW-1:0] cnt_q;
  logic signed [16:0] qx_q, qy_q;
  logic signed [15:0] cx_q, cy_q, ax_q, ay_q, bx_q, by_q;
  logic [31:0] rd_data;
  logic [31:0] wr_data;
  logic below_q;

  logic signed [16:0] dax, day;
  logic signed [33:0] p0_q, p1_q;
  logic signed [31:0] p2_q, p3_q;
  logic signed [50:0] num_q;
  logic signed [32:0] den_q;
  logic [49:0] rem_q, dvd_q;
  logic [32:0] dvs_q;
  logic [49:0] quo_q;
  logic [5:0]  it_q;
  logic        neg_q;

  cpgd_ram #(.Width(32), .Depth(MaxVertices)) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(wr_addr_i),
    .wdata_i(wr_data),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_addr_i),
    .rdata_o(rd_data)
  );

  assign wr_data = cmd_i.wr_new ? {req_q.first_x, req_q.first_y} : {cx_q, cy_q};

  // Vertex count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.clr_cnt) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  // Request capture and vertex latches.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_i;
      qx_q  <= 17'(req_i.first_x) - 17'(req_i.second_x);
      qy_q  <= 17'(req_i.first_y) - 17'(req_i.second_y);
    end
    if (cmd_i.lat_rd) begin
      cx_q <= rd_data[31:16];
      cy_q <= rd_data[15:0];
    end
    if (cmd_i.lat_a) begin
      ax_q <= rd_data[31:16];
      ay_q <= rd_data[15:0];
    end
    if (cmd_i.lat_b) begin
      bx_q <= rd_data[31:16];
      by_q <= rd_data[15:0];
    end
  end

  // Compare on the latched vertex: insert tests new below stored, query tests stored below Q.
  always_ff @(posedge clk_i) begin
    if (req_q.cmd == CmdInsert) begin
      below_q <= ang_below(17'(req_q.first_x), 17'(req_q.first_y), 17'(cx_q), 17'(cy_q));
    end else begin
      below_q <= ang_below(17'(cx_q), 17'(cy_q), qx_q, qy_q);
    end
  end

  // Products in two steps: multipliers in the first register, differences in the second.
  assign dax = 17'(ax_q) - 17'(bx_q);
  assign day = 17'(ay_q) - 17'(by_q);
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      p0_q <= qx_q * day;
      p1_q <= qy_q * dax;
      p2_q <= by_q * ax_q;
      p3_q <= bx_q * ay_q;
    end
    if (cmd_i.mul2) begin
      num_q <= (51'(p1_q) - 51'(p0_q)) <<< 16;
      den_q <= 33'(p2_q) - 33'(p3_q);
    end
  end

  // Restoring divider on magnitudes, one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_q <= num_q[50] ^ den_q[32];
      dvd_q <= num_q[50] ? 50'(-num_q) : 50'(num_q);
      dvs_q <= den_q[32] ? 33'(-den_q) : 33'(den_q);
      rem_q <= '0;
      quo_q <= '0;
      it_q  <= 6'd50;
    end else if (cmd_i.div_step && it_q != 6'd0) begin
      logic [50:0] trial;
      trial = {rem_q, dvd_q[49]} - 51'(dvs_q);
      dvd_q <= {dvd_q[48:0], 1'b0};
      if (!trial[50]) begin
        rem_q <= trial[49:0];
        quo_q <= {quo_q[48:0], 1'b1};
      end else begin
        rem_q <= {rem_q[48:0], dvd_q[49]};
        quo_q <= {quo_q[48:0], 1'b0};
      end
      it_q <= it_q - 6'd1;
    end
  end

  // Signed saturation of the quotient.
  always_comb begin
    rsp_o = '0;
    if (neg_q) begin
      if (quo_q > 50'h80000000) rsp_o.distance = 32'sh80000000;
      else rsp_o.distance = 32'(-quo_q);
    end else begin
      if (quo_q > 50'h7fffffff) rsp_o.distance = 32'sh7fffffff;
      else rsp_o.distance = quo_q[31:0];
    end
  end

  assign sts_o.below    = below_q;
  assign sts_o.full     = (cnt_q >= CW'(MaxVertices));
  assign sts_o.empty    = (cnt_q == '0);
  assign sts_o.q_zero   = (qx_q == 0) && (qy_q == 0);
  assign sts_o.den_zero = (den_q == 0);
  assign sts_o.div_done = (it_q == 6'd0);
  assign count_o        = cnt_q;
  assign cmd_code_o     = req_q.cmd;
endmodule

@@ hdl/cpgd_ctrl.sv @@
`timescale 1ns / 1ps
module cpgd_ctrl import cpgd_pkg::*; #(
  parameter int unsigned MaxVertices = MaxVerticesDefault,
  localparam int unsigned AW = $clog2(MaxVertices),
  localparam int unsigned CW = $clog2(MaxVertices + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  sts_t          sts_i,
  input  logic [CW-1:0] count_i,
  input  logic [1:0]    cmd_code_i,
  output cmd_t          cmd_o,
  output logic [AW-1:0] rd_addr_o,
  output logic [AW-1:0] wr_addr_o,
  output logic          err_o,
  output logic          zero_o
);
  typedef enum logic [4:0] {
    SIdle, SDecode, SInsRd, SInsLat, SInsCmp, SInsDec,
    SQRd, SQLat, SQCmp, SQEval, SQRdA, SQRdB, SQLatB, SQMul, SQMul2, SQDiv,
    SOut
  } state_e;
  state_e state_q;
  logic [CW-1:0] pos_q;
  logic [AW-1:0] a_q;
  logic err_q, zero_q;
  logic start_div_q;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);
  assign err_o       = err_q;
  assign zero_o      = zero_q;

  // Commands are decoded from the state.
  always_comb begin
    cmd_o     = '0;
    rd_addr_o = pos_q[AW-1:0];
    wr_addr_o = pos_q[AW-1:0];
    unique case (state_q)
      SIdle:   cmd_o.load_req = in_valid_i;
      SDecode: cmd_o.clr_cnt = (cmd_code_i == CmdClear);
      SInsRd:  begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = AW'(pos_q - CW'(1));
      end
      SInsLat: cmd_o.lat_rd = 1'b1;
      SInsCmp: ;
      SInsDec: begin
        if (pos_q != '0 && sts_i.below) begin
          cmd_o.wr_en = 1'b1;
        end else begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_new  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
        end
      end
      SQRd:    cmd_o.rd_en = 1'b1;
      SQLat:   cmd_o.lat_rd = 1'b1;
      SQRdA:   begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = a_q;
      end
      SQRdB:   begin
        cmd_o.lat_a = 1'b1;
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = (a_q == '0) ? AW'(count_i - CW'(1)) : a_q - AW'(1);
      end
      SQLatB:  cmd_o.lat_b = 1'b1;
      SQMul:   cmd_o.mul_start = 1'b1;
      SQMul2:  cmd_o.mul2 = 1'b1;
      SQDiv:   begin
        cmd_o.div_start = start_div_q;
        cmd_o.div_step  = !start_div_q;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      pos_q       <= '0;
      a_q         <= '0;
      err_q       <= 1'b0;
      zero_q      <= 1'b1;
      start_div_q <= 1'b0;
    end else begin
      start_div_q <= 1'b0;
      unique case (state_q)
        SIdle: if (in_valid_i) state_q <= SDecode;
        SDecode: begin
          err_q  <= 1'b0;
          zero_q <= 1'b1;
          pos_q  <= count_i;
          priority case (cmd_code_i)
            CmdInsert: begin
              if (sts_i.full) begin
                err_q   <= 1'b1;
                state_q <= SOut;
              end else if (sts_i.empty) begin
                state_q <= SInsDec;
              end else begin
                state_q <= SInsRd;
              end
            end
            CmdQuery: begin
              if (sts_i.q_zero) state_q <= SOut;
              else if (sts_i.empty) begin
                err_q   <= 1'b1;
                state_q <= SOut;
              end else begin
                pos_q   <= '0;
                state_q <= SQRd;
              end
            end
            default: state_q <= SIdle;
          endcase
        end
        SInsRd:  state_q <= SInsLat;
        SInsLat: state_q <= SInsCmp;
        SInsCmp: state_q <= SInsDec;
        SInsDec: begin
          if (pos_q != '0 && sts_i.below) begin
            pos_q <= pos_q - CW'(1);
            if (pos_q == CW'(1)) state_q <= SInsDec;
            else state_q <= SInsRd;
          end else begin
            state_q <= SOut;
          end
        end
        SQRd:  state_q <= SQLat;
        SQLat: state_q <= SQCmp;
        SQCmp: state_q <= SQEval;
        SQEval: begin
          if (sts_i.below && pos_q + CW'(1) < count_i) begin
            pos_q   <= pos_q + CW'(1);
            state_q <= SQRd;
          end else begin
            a_q     <= sts_i.below ? '0 : pos_q[AW-1:0];
            state_q <= SQRdA;
          end
        end
        SQRdA:  state_q <= SQRdB;
        SQRdB:  state_q <= SQLatB;
        SQLatB: state_q <= SQMul;
        SQMul:  state_q <= SQMul2;
        SQMul2: begin
          start_div_q <= 1'b1;
          state_q     <= SQDiv;
        end
        SQDiv: begin
          if (start_div_q) begin
            if (sts_i.den_zero) begin
              err_q   <= 1'b1;
              state_q <= SOut;
            end
          end else if (sts_i.div_done) begin
            zero_q  <= 1'b0;
            state_q <= SOut;
          end
        end
        SOut: if (out_ready_i) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

@@ hdl/convex_polygon_gauge_distance.sv @@
`timescale 1ns / 1ps
// An insert compares the new vertex against the stored ones, from the last one down;
// a query scans the stored vertices and then runs a 50-step divider.
// Throughput: one request at a time; the next is taken the cycle after the result is taken.
// Reset clears the vertex count and the sequencer; the vertex memory is not cleared.
module convex_polygon_gauge_distance import cpgd_pkg::*; #(
  parameter int unsigned MaxVertices = MaxVerticesDefault
) (
  input logic clk_i,
  input logic rst_ni,
  cpgd_if.sink   in_i,
  cpgd_if.source out_o
);
  localparam int unsigned AW = $clog2(MaxVertices);
  localparam int unsigned CW = $clog2(MaxVertices + 1);
  cmd_t cmd;
  sts_t sts;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [CW-1:0] count;
  logic [1:0] cmd_code;
  rsp_t dp_rsp;
  logic err, zero;

  cpgd_ctrl #(.MaxVertices(MaxVertices)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_i.valid), .in_ready_o(in_i.ready),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready),
    .sts_i(sts), .count_i(count), .cmd_code_i(cmd_code), .cmd_o(cmd),
    .rd_addr_o(rd_addr), .wr_addr_o(wr_addr), .err_o(err), .zero_o(zero)
  );

  cpgd_datapath #(.MaxVertices(MaxVertices)) u_dp (
    .clk_i, .rst_ni, .req_i(in_i.data), .cmd_i(cmd),
    .rd_addr_i(rd_addr), .wr_addr_i(wr_addr), .sts_o(sts),
    .count_o(count), .cmd_code_o(cmd_code), .rsp_o(dp_rsp)
  );

  assign out_o.data.distance = zero ? 32'sd0 : dp_rsp.distance;
  assign out_o.data.error    = err;
endmodule

@@ hdl/cpgd_checker.sv @@
`timescale 1ns / 1ps
module cpgd_checker import cpgd_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);
  // Never ready for a new request while a result waits.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("ready during pending result");
  // A result never appears right after acceptance.
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  // An error result carries distance zero.
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_data.error) |-> (out_data.distance == 0)) else $error("error with value");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data))) else $error("result dropped");
endmodule

bind convex_polygon_gauge_distance cpgd_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready), .out_data(out_o.data)
);
